// ===== hdl/vip_pkg.sv =====
// Shared types, constants and register codes for the valve incremental PID block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package vip_pkg;

   // Field widths
   localparam int POS_W      = 24;   // signed Q.10 positions and errors
   localparam int ERR_W      = 25;   // error after subtract, signed
   localparam int MAG_W      = 24;   // stored error magnitudes
   localparam int GAIN_W     = 16;   // unsigned Q.12 gains
   localparam int DBAND_W    = 23;
   localparam int DIFF2_W    = 27;   // m - 2p + l, signed
   localparam int OUT_PULSE_W = 9;
   localparam int CODE_W     = 2;

   // Shared multiplier: signed A by unsigned B
   localparam int MUL_A_W    = 28;
   localparam int MUL_B_W    = 18;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = PROD_W;

   // Pulse scaling: pulse = floor(|term| * PULSE_MAX / (5 * 2^22))
   localparam int TERM_FRAC  = 22;
   localparam int ATERM_W    = 25;   // |term| below the saturation limit
   localparam logic [ACC_W-1:0] SAT_LIMIT = ACC_W'(5) << TERM_FRAC;
   localparam int DIV5_SHIFT = 20;
   localparam logic [MUL_B_W-1:0] DIV5_RECIP = MUL_B_W'(209715);  // floor(2^20 / 5)

   localparam int PULSE_MAX_DEFAULT = 500;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DEADBAND  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CLAMP_HI  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CLAMP_LO  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_THR  = 3'd7;

   localparam logic signed [POS_W-1:0] TARGET_RST   = 24'sd28262;
   localparam logic [GAIN_W-1:0]       GAIN_P_RST   = 16'd369;
   localparam logic [GAIN_W-1:0]       GAIN_I_RST   = 16'd778;
   localparam logic [GAIN_W-1:0]       GAIN_D_RST   = 16'd410;
   localparam logic [DBAND_W-1:0]      DEADBAND_RST = 23'd1024;
   localparam logic signed [POS_W-1:0] CLAMP_HI_RST = 24'sd5120;
   localparam logic signed [POS_W-1:0] CLAMP_LO_RST = -24'sd5120;
   localparam logic [DBAND_W-1:0]      FULL_THR_RST = 23'd2048;

   // Result codes
   localparam logic [CODE_W-1:0] DIR_INPUT   = 2'd0;
   localparam logic [CODE_W-1:0] DIR_OUTPUT  = 2'd1;
   localparam logic [CODE_W-1:0] DIR_NONE    = 2'd2;
   localparam logic [CODE_W-1:0] OPEN_CLOSED = 2'd0;
   localparam logic [CODE_W-1:0] OPEN_HALF   = 2'd1;
   localparam logic [CODE_W-1:0] OPEN_FULL   = 2'd2;

   // Datapath operations issued by the controller
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
   localparam logic [OP_W-1:0] OP_CLAMP = 4'd1;
   localparam logic [OP_W-1:0] OP_MP    = 4'd2;
   localparam logic [OP_W-1:0] OP_MI    = 4'd3;
   localparam logic [OP_W-1:0] OP_MD    = 4'd4;
   localparam logic [OP_W-1:0] OP_ABS   = 4'd5;
   localparam logic [OP_W-1:0] OP_SCALE = 4'd6;
   localparam logic [OP_W-1:0] OP_DIV   = 4'd7;
   localparam logic [OP_W-1:0] OP_FIX   = 4'd8;
   localparam logic [OP_W-1:0] OP_HOLD  = 4'd9;

   typedef struct packed {
      logic signed [POS_W-1:0] setpoint;
      logic [GAIN_W-1:0]       gain_p;
      logic [GAIN_W-1:0]       gain_i;
      logic [GAIN_W-1:0]       gain_d;
      logic [DBAND_W-1:0]      deadband;
      logic signed [POS_W-1:0] clamp_high;
      logic signed [POS_W-1:0] clamp_low;
      logic [DBAND_W-1:0]      full_open_threshold;
   } cfg_type;

   typedef struct packed {
      logic            capture;
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic in_deadband;
   } status_type;

endpackage

// ===== hdl/vip_csr.sv =====
// Configuration registers of the valve PID block, written through a plain write port.
// Depends on vip_pkg.
`timescale 1ns / 1ps

module vip_csr
   import vip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_TARGET:   cfg_in.setpoint            = $signed(csr_write_data[POS_W-1:0]);
            REG_GAIN_P:   cfg_in.gain_p              = csr_write_data[GAIN_W-1:0];
            REG_GAIN_I:   cfg_in.gain_i              = csr_write_data[GAIN_W-1:0];
            REG_GAIN_D:   cfg_in.gain_d              = csr_write_data[GAIN_W-1:0];
            REG_DEADBAND: cfg_in.deadband            = csr_write_data[DBAND_W-1:0];
            REG_CLAMP_HI: cfg_in.clamp_high          = $signed(csr_write_data[POS_W-1:0]);
            REG_CLAMP_LO: cfg_in.clamp_low           = $signed(csr_write_data[POS_W-1:0]);
            REG_FULL_THR: cfg_in.full_open_threshold = csr_write_data[DBAND_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint            <= TARGET_RST;
         cfg_ff.gain_p              <= GAIN_P_RST;
         cfg_ff.gain_i              <= GAIN_I_RST;
         cfg_ff.gain_d              <= GAIN_D_RST;
         cfg_ff.deadband            <= DEADBAND_RST;
         cfg_ff.clamp_high          <= CLAMP_HI_RST;
         cfg_ff.clamp_low           <= CLAMP_LO_RST;
         cfg_ff.full_open_threshold <= FULL_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/vip_ctrl.sv =====
// Sequencing state machine: takes a word, steps the datapath, hands off the result.
// Depends on vip_pkg.
`timescale 1ns / 1ps

module vip_ctrl
   import vip_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [ST_W-1:0] ST_CLAMP = 4'd1;
   localparam logic [ST_W-1:0] ST_MP    = 4'd2;
   localparam logic [ST_W-1:0] ST_MI    = 4'd3;
   localparam logic [ST_W-1:0] ST_MD    = 4'd4;
   localparam logic [ST_W-1:0] ST_ABS   = 4'd5;
   localparam logic [ST_W-1:0] ST_SCALE = 4'd6;
   localparam logic [ST_W-1:0] ST_DIV   = 4'd7;
   localparam logic [ST_W-1:0] ST_FIX   = 4'd8;

   logic [ST_W-1:0] state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.capture  = 1'b0;
      cmd.op       = OP_NONE;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (status.in_deadband) begin
               // hold here until the output word has room
               if (out_free) begin
                  cmd.op       = OP_HOLD;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.op   = OP_CLAMP;
               state_in = ST_MP;
            end
         end
         ST_MP: begin
            cmd.op   = OP_MP;
            state_in = ST_MI;
         end
         ST_MI: begin
            cmd.op   = OP_MI;
            state_in = ST_MD;
         end
         ST_MD: begin
            cmd.op   = OP_MD;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            cmd.op   = OP_ABS;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op   = OP_DIV;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            if (out_free) begin
               cmd.op       = OP_FIX;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/vip_datapath.sv =====
// Error, clamp, incremental PID term and pulse scaling over one shared multiplier.
// Depends on vip_pkg; steered by vip_ctrl through cmd_type.
`timescale 1ns / 1ps

module vip_datapath
   import vip_pkg::*;
#(
   parameter int PULSE_MAX = PULSE_MAX_DEFAULT
)(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic signed [POS_W-1:0] req_measured_position,
   output logic [OUT_PULSE_W-1:0]  rsp_pulse_time,
   output logic [CODE_W-1:0]       rsp_valve_direction,
   output logic [CODE_W-1:0]       rsp_open_size,
   output logic                    rsp_correcting
);

   localparam int PW  = (PULSE_MAX > 1) ? $clog2(PULSE_MAX + 1) : 1;
   localparam int QW  = PW + 3;
   localparam int PXW = (PW > OUT_PULSE_W) ? PW : OUT_PULSE_W;
   localparam logic [PW-1:0] PMAX = PW'(PULSE_MAX);

   // state kept across words
   logic [MAG_W-1:0]  prev_mag_ff, prev_mag_in;
   logic [MAG_W-1:0]  older_mag_ff, older_mag_in;
   logic [CODE_W-1:0] held_dir_ff, held_dir_in;
   logic [CODE_W-1:0] held_open_ff, held_open_in;

   // per-word working registers
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ATERM_W-1:0]      aterm_ff, aterm_in;
   logic                    sat_ff, sat_in;
   logic [QW-1:0]           q_ff, q_in;
   logic [PW-1:0]           est_ff, est_in;

   // result word
   logic [PW-1:0]     pulse_ff, pulse_in;
   logic [CODE_W-1:0] out_dir_ff, out_dir_in;
   logic [CODE_W-1:0] out_open_ff, out_open_in;
   logic              out_corr_ff, out_corr_in;

   // combinational helpers
   logic [ERR_W-1:0]          mag_raw;
   logic signed [ERR_W-1:0]   clamped;
   logic [ERR_W-1:0]          clamped_abs;
   logic [MAG_W-1:0]          mag_sat;
   logic signed [ERR_W-1:0]   diff1;
   logic signed [DIFF2_W-1:0] diff2;
   logic signed [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic signed [PROD_W-1:0]  mul_prod;
   logic [ACC_W-1:0]          acc_abs;
   logic [QW-1:0]             rem;
   logic [PXW-1:0]            pulse_wide;

   assign mag_raw = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign status.in_deadband = (mag_raw <= {2'b00, cfg.deadband});

   // upper bound first, then lower, as written even if the bounds cross
   always_comb begin
      if (err_ff > $signed({cfg.clamp_high[POS_W-1], cfg.clamp_high})) begin
         clamped = $signed({cfg.clamp_high[POS_W-1], cfg.clamp_high});
      end else if (err_ff < $signed({cfg.clamp_low[POS_W-1], cfg.clamp_low})) begin
         clamped = $signed({cfg.clamp_low[POS_W-1], cfg.clamp_low});
      end else begin
         clamped = err_ff;
      end
   end

   assign clamped_abs = clamped[ERR_W-1] ? ERR_W'(-clamped) : ERR_W'(clamped);
   assign mag_sat     = clamped_abs[ERR_W-1] ? {MAG_W{1'b1}} : clamped_abs[MAG_W-1:0];

   assign diff1 = $signed({1'b0, mag_ff}) - $signed({1'b0, prev_mag_ff});
   assign diff2 = $signed({3'b000, mag_ff}) - $signed({2'b00, prev_mag_ff, 1'b0})
                + $signed({3'b000, older_mag_ff});

   // operand steering for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MP: begin
            mul_a = MUL_A_W'(diff1);
            mul_b = MUL_B_W'(cfg.gain_p);
         end
         OP_MI: begin
            mul_a = $signed(MUL_A_W'(mag_ff));
            mul_b = MUL_B_W'(cfg.gain_i);
         end
         OP_MD: begin
            mul_a = MUL_A_W'(diff2);
            mul_b = MUL_B_W'(cfg.gain_d);
         end
         OP_SCALE: begin
            mul_a = $signed(MUL_A_W'(aterm_ff));
            mul_b = MUL_B_W'(PULSE_MAX);
         end
         OP_DIV: begin
            mul_a = $signed(MUL_A_W'(q_ff));
            mul_b = DIV5_RECIP;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = mul_a * $signed({1'b0, mul_b});
   assign acc_abs  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign rem      = q_ff - QW'({est_ff, 2'b00}) - QW'(est_ff);

   always_comb begin
      prev_mag_in  = prev_mag_ff;
      older_mag_in = older_mag_ff;
      held_dir_in  = held_dir_ff;
      held_open_in = held_open_ff;
      err_in       = err_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      aterm_in     = aterm_ff;
      sat_in       = sat_ff;
      q_in         = q_ff;
      est_in       = est_ff;
      pulse_in     = pulse_ff;
      out_dir_in   = out_dir_ff;
      out_open_in  = out_open_ff;
      out_corr_in  = out_corr_ff;

      if (cmd.capture) begin
         err_in = $signed({cfg.setpoint[POS_W-1], cfg.setpoint})
                - $signed({req_measured_position[POS_W-1], req_measured_position});
      end

      case (cmd.op)
         OP_CLAMP: begin
            mag_in       = mag_sat;
            held_open_in = (mag_sat >= {1'b0, cfg.full_open_threshold}) ? OPEN_FULL
                                                                       : OPEN_HALF;
            held_dir_in  = clamped[ERR_W-1] ? DIR_INPUT : DIR_OUTPUT;
         end
         OP_MP: begin
            acc_in = mul_prod;
         end
         OP_MI: begin
            acc_in = acc_ff + mul_prod;
         end
         OP_MD: begin
            acc_in       = acc_ff + mul_prod;
            older_mag_in = prev_mag_ff;
            prev_mag_in  = mag_ff;
         end
         OP_ABS: begin
            sat_in   = (acc_abs >= SAT_LIMIT);
            aterm_in = acc_abs[ATERM_W-1:0];
         end
         OP_SCALE: begin
            q_in = mul_prod[TERM_FRAC +: QW];
         end
         OP_DIV: begin
            // reciprocal estimate is exact or one low
            est_in = mul_prod[DIV5_SHIFT +: PW];
         end
         OP_FIX: begin
            if (sat_ff) begin
               pulse_in = PMAX;
            end else if (rem >= QW'(5)) begin
               pulse_in = est_ff + PW'(1);
            end else begin
               pulse_in = est_ff;
            end
            out_dir_in  = held_dir_ff;
            out_open_in = held_open_ff;
            out_corr_in = 1'b1;
         end
         OP_HOLD: begin
            pulse_in    = '0;
            out_dir_in  = held_dir_ff;
            out_open_in = held_open_ff;
            out_corr_in = 1'b0;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mag_ff  <= '0;
         older_mag_ff <= '0;
         held_dir_ff  <= DIR_NONE;
         held_open_ff <= OPEN_CLOSED;
      end else begin
         prev_mag_ff  <= prev_mag_in;
         older_mag_ff <= older_mag_in;
         held_dir_ff  <= held_dir_in;
         held_open_ff <= held_open_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      mag_ff      <= mag_in;
      acc_ff      <= acc_in;
      aterm_ff    <= aterm_in;
      sat_ff      <= sat_in;
      q_ff        <= q_in;
      est_ff      <= est_in;
      pulse_ff    <= pulse_in;
      out_dir_ff  <= out_dir_in;
      out_open_ff <= out_open_in;
      out_corr_ff <= out_corr_in;
   end

   assign pulse_wide          = PXW'(pulse_ff);
   assign rsp_pulse_time      = pulse_wide[OUT_PULSE_W-1:0];
   assign rsp_valve_direction = out_dir_ff;
   assign rsp_open_size       = out_open_ff;
   assign rsp_correcting      = out_corr_ff;

endmodule

// ===== hdl/valve_incremental_pid_top.sv =====
// Channel    | Ports                                   | Direction
// req        | req_valid, req_stall, req_measured_*    | in (stall out)
// rsp        | rsp_valid, rsp_stall, rsp_pulse_time... | out (stall in)
// csr        | csr_write_en, csr_index, csr_write_data | in
//
// A new word is accepted only once the last result is in the output register; outside
// the deadband, five steps share one 28x19 multiplier (three PID products, scale,
// divide by five); inside it they are skipped. The result sits in an output register,
// so a stalled result holds while the next word is already accepted and worked on.
// Reset is synchronous and active high; it restores the register defaults and history.
// Top level of the valve incremental PID block; depends on vip_pkg, vip_csr,
// vip_ctrl and vip_datapath.
`timescale 1ns / 1ps

module valve_incremental_pid_top
   import vip_pkg::*;
#(
   parameter int PULSE_MAX = PULSE_MAX_DEFAULT
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [POS_W-1:0] req_measured_position,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [OUT_PULSE_W-1:0]  rsp_pulse_time,
   output logic [CODE_W-1:0]       rsp_valve_direction,
   output logic [CODE_W-1:0]       rsp_open_size,
   output logic                    rsp_correcting,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   vip_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   vip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vip_datapath #(
      .PULSE_MAX (PULSE_MAX)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .cmd                   (cmd),
      .status                (status),
      .req_measured_position (req_measured_position),
      .rsp_pulse_time        (rsp_pulse_time),
      .rsp_valve_direction   (rsp_valve_direction),
      .rsp_open_size         (rsp_open_size),
      .rsp_correcting        (rsp_correcting)
   );

endmodule

// ===== hdl/vip_checker.sv =====
// Port-level checks for the valve PID block, bound to the top level.
// Depends on vip_pkg and valve_incremental_pid_top.
`timescale 1ns / 1ps

module vip_checker
   import vip_pkg::*;
#(
   parameter int PULSE_MAX = PULSE_MAX_DEFAULT
)(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [OUT_PULSE_W-1:0] rsp_pulse_time,
   input logic [CODE_W-1:0]      rsp_valve_direction,
   input logic [CODE_W-1:0]      rsp_open_size,
   input logic                   rsp_correcting
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pulse_time)
         && $stable(rsp_valve_direction) && $stable(rsp_open_size)
         && $stable(rsp_correcting))
      else $error("result word changed while stalled");

   // one word at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted twice in a row");

   a_deadband_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_correcting |-> rsp_pulse_time == '0)
      else $error("nonzero pulse inside deadband");

   a_correct_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_correcting |-> rsp_valve_direction != DIR_NONE
         && rsp_open_size != OPEN_CLOSED)
      else $error("correcting word without direction or opening");

   a_pulse_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (PULSE_MAX >= (1 << OUT_PULSE_W))
         || (32'(rsp_pulse_time) <= 32'(PULSE_MAX)))
      else $error("pulse above its maximum");

endmodule

bind valve_incremental_pid_top vip_checker #(
   .PULSE_MAX (PULSE_MAX)
) u_vip_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_pulse_time      (rsp_pulse_time),
   .rsp_valve_direction (rsp_valve_direction),
   .rsp_open_size       (rsp_open_size),
   .rsp_correcting      (rsp_correcting)
);

// ===== test/tb_valve_incremental_pid_top.sv =====
// Self-checking bench for valve_incremental_pid_top: predicts each valve command from the
// measured position and the live register settings, then checks every response word.
// Depends on vip_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_valve_incremental_pid_top;
   import vip_pkg::*;

   localparam int     PULSE_LIMIT   = PULSE_MAX_DEFAULT;
   localparam longint PULSE_DIVISOR = longint'(5) << TERM_FRAC;
   localparam longint MAG_CEIL      = (longint'(1) << MAG_W) - 1;

   typedef struct packed {
      logic [OUT_PULSE_W-1:0] pulse_time;
      logic [CODE_W-1:0]      valve_direction;
      logic [CODE_W-1:0]      open_size;
      logic                   correcting;
   } valve_move_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [POS_W-1:0] req_measured_position;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [OUT_PULSE_W-1:0]  rsp_pulse_time;
   logic [CODE_W-1:0]       rsp_valve_direction;
   logic [CODE_W-1:0]       rsp_open_size;
   logic                    rsp_correcting;
   logic                    csr_write_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_write_data;

   // Predictor copy of the registers and the controller history
   cfg_type           settings;
   logic [MAG_W-1:0]  last_mag;
   logic [MAG_W-1:0]  older_mag;
   logic [CODE_W-1:0] held_dir;
   logic [CODE_W-1:0] held_open;

   valve_move_type expected_moves[$];
   int             mismatches    = 0;
   int             send_idle_pct = 0;
   int             stall_pct     = 0;

   valve_incremental_pid_top #(
      .PULSE_MAX(PULSE_LIMIT)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_measured_position (req_measured_position),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_pulse_time        (rsp_pulse_time),
      .rsp_valve_direction   (rsp_valve_direction),
      .rsp_open_size         (rsp_open_size),
      .rsp_correcting        (rsp_correcting),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_valve_incremental_pid_top: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
   endtask

   // Work out the valve command for one accepted position and advance the history.
   function automatic valve_move_type predict_move(input logic signed [POS_W-1:0] pos);
      valve_move_type move;
      longint         err;
      longint         mag;
      longint         hist_p;
      longint         hist_l;
      longint         term;
      longint         pulse;
      err = longint'($signed(settings.setpoint)) - longint'(pos);
      mag = (err < 0) ? -err : err;
      move.pulse_time = '0;
      move.correcting = 1'b0;
      if (mag <= longint'(settings.deadband)) begin
         move.valve_direction = held_dir;
         move.open_size       = held_open;
         return move;
      end
      // upper bound first, then lower, even when the bounds are crossed
      if (err > longint'($signed(settings.clamp_high))) begin
         err = longint'($signed(settings.clamp_high));
      end else if (err < longint'($signed(settings.clamp_low))) begin
         err = longint'($signed(settings.clamp_low));
      end
      mag = (err < 0) ? -err : err;
      if (mag > MAG_CEIL) begin
         mag = MAG_CEIL;
      end
      held_open = (mag >= longint'(settings.full_open_threshold)) ? OPEN_FULL : OPEN_HALF;
      held_dir  = (err >= 0) ? DIR_OUTPUT : DIR_INPUT;
      hist_p = longint'(last_mag);
      hist_l = longint'(older_mag);
      term = longint'(settings.gain_p) * (mag - hist_p)
           + longint'(settings.gain_i) * mag
           + longint'(settings.gain_d) * (mag - 2 * hist_p + hist_l);
      if (term < 0) begin
         term = -term;
      end
      pulse = term * PULSE_LIMIT / PULSE_DIVISOR;
      if (pulse > PULSE_LIMIT) begin
         pulse = PULSE_LIMIT;
      end
      older_mag = last_mag;
      last_mag  = mag[MAG_W-1:0];
      move.pulse_time      = pulse[OUT_PULSE_W-1:0];
      move.valve_direction = held_dir;
      move.open_size       = held_open;
      move.correcting      = 1'b1;
      return move;
   endfunction

   // Response checker: compare each accepted word with the oldest expectation.
   initial begin
      valve_move_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (expected_moves.size() == 0) begin
               report_mismatch("unexpected response word", 0, 1);
            end else begin
               want = expected_moves.pop_front();
               if (rsp_pulse_time !== want.pulse_time)
                  report_mismatch("pulse_time", want.pulse_time, rsp_pulse_time);
               if (rsp_valve_direction !== want.valve_direction)
                  report_mismatch("valve_direction", want.valve_direction, rsp_valve_direction);
               if (rsp_open_size !== want.open_size)
                  report_mismatch("open_size", want.open_size, rsp_open_size);
               if (rsp_correcting !== want.correcting)
                  report_mismatch("correcting", want.correcting, rsp_correcting);
            end
         end
      end
   end

   // Receiver back-pressure
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_position(input logic signed [POS_W-1:0] pos);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid             = 1'b0;
         req_measured_position = POS_W'($urandom);
         @(negedge clock);
      end
      req_valid             = 1'b1;
      req_measured_position = pos;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_moves.push_back(predict_move(pos));
   endtask

   // Drop valid and wait until every expected word has come back.
   task automatic drain_moves();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_moves.size() != 0) @(posedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_index      = index;
      csr_write_data = data;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (index)
         REG_TARGET:   settings.setpoint            = data;
         REG_GAIN_P:   settings.gain_p              = data[GAIN_W-1:0];
         REG_GAIN_I:   settings.gain_i              = data[GAIN_W-1:0];
         REG_GAIN_D:   settings.gain_d              = data[GAIN_W-1:0];
         REG_DEADBAND: settings.deadband            = data[DBAND_W-1:0];
         REG_CLAMP_HI: settings.clamp_high          = data;
         REG_CLAMP_LO: settings.clamp_low           = data;
         REG_FULL_THR: settings.full_open_threshold = data[DBAND_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_random_settings();
      logic [CSR_DATA_W-1:0] hi;
      logic [CSR_DATA_W-1:0] lo;
      logic [CSR_DATA_W-1:0] swap;
      int                    shape;
      shape = $urandom_range(0, 9);
      write_register(REG_TARGET, CSR_DATA_W'($urandom));
      // upper data bits of the narrow registers are junk and must be dropped
      write_register(REG_GAIN_P, (shape == 0) ? CSR_DATA_W'($urandom)
                                 : {8'($urandom), 16'($urandom_range(0, 1500))});
      write_register(REG_GAIN_I, (shape == 0) ? CSR_DATA_W'($urandom)
                                 : {8'($urandom), 16'($urandom_range(0, 1500))});
      write_register(REG_GAIN_D, (shape == 0) ? CSR_DATA_W'($urandom)
                                 : {8'($urandom), 16'($urandom_range(0, 1500))});
      write_register(REG_DEADBAND, (shape == 1) ? CSR_DATA_W'($urandom)
                                   : {1'($urandom), 23'($urandom_range(0, 3000))});
      hi = CSR_DATA_W'($urandom_range(300, 12000));
      lo = CSR_DATA_W'(-int'($urandom_range(300, 12000)));
      if (shape == 2) begin
         swap = hi;
         hi   = lo;
         lo   = swap;
      end else if (shape == 3) begin
         hi = CSR_DATA_W'($urandom);
         lo = CSR_DATA_W'($urandom);
      end
      write_register(REG_CLAMP_HI, hi);
      write_register(REG_CLAMP_LO, lo);
      write_register(REG_FULL_THR, {1'($urandom), 23'($urandom_range(0, 9000))});
   endtask

   // Mostly positions around the setpoint so the history builds up; some full-range noise.
   function automatic logic signed [POS_W-1:0] pick_position();
      longint span;
      longint offset;
      int     pick;
      span = longint'(settings.deadband) + 8000;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         offset = longint'($urandom_range(0, 32'(2 * span))) - span;
      end else if (pick < 9) begin
         return POS_W'($urandom);
      end else begin
         offset = longint'(settings.deadband) + $urandom_range(0, 1);
         if ($urandom_range(0, 1)) offset = -offset;
      end
      return POS_W'(longint'($signed(settings.setpoint)) - offset);
   endfunction

   task automatic run_random_block(input int count, input bit pause_midway);
      load_random_settings();
      for (int n = 0; n < count; n++) begin
         if (pause_midway && n == count / 2) begin
            drain_moves();
         end
         send_position(pick_position());
      end
      drain_moves();
   endtask

   task automatic test_deadband_edges();
      send_position(TARGET_RST);
      send_position(TARGET_RST - 24'sd1024);
      send_position(TARGET_RST - 24'sd1025);
      send_position(TARGET_RST + 24'sd1025);
      send_position(TARGET_RST + 24'sd1024);
   endtask

   task automatic test_position_extremes();
      send_position(24'sh800000);
      send_position(24'sh7FFFFF);
      send_position(24'sd0);
      send_position(-24'sd1);
      drain_moves();
   endtask

   task automatic test_register_extremes();
      write_register(REG_TARGET, 24'h800000);
      write_register(REG_GAIN_P, 24'hA5FFFF);
      write_register(REG_GAIN_I, 24'h5AFFFF);
      write_register(REG_GAIN_D, 24'hFFFFFF);
      write_register(REG_DEADBAND, 24'h800000);
      write_register(REG_CLAMP_HI, 24'h7FFFFF);
      write_register(REG_CLAMP_LO, 24'h800000);
      write_register(REG_FULL_THR, 24'hFFFFFF);
      send_position(24'sh7FFFFF);
      send_position(24'sh800000);
      send_position(24'sh800001);
      drain_moves();
      write_register(REG_TARGET, 24'h7FFFFF);
      write_register(REG_GAIN_P, 24'h000000);
      write_register(REG_GAIN_I, 24'hFF0000);
      write_register(REG_GAIN_D, 24'h000000);
      write_register(REG_DEADBAND, 24'h7FFFFF);
      write_register(REG_FULL_THR, 24'h000000);
      send_position(24'sh800000);
      send_position(24'sd0);
      send_position(24'sh7FFFFF);
      drain_moves();
   endtask

   task automatic test_crossed_clamps();
      write_register(REG_TARGET, 24'h000000);
      write_register(REG_GAIN_P, CSR_DATA_W'(GAIN_P_RST));
      write_register(REG_GAIN_I, CSR_DATA_W'(GAIN_I_RST));
      write_register(REG_GAIN_D, CSR_DATA_W'(GAIN_D_RST));
      write_register(REG_DEADBAND, 24'h000000);
      write_register(REG_CLAMP_HI, CSR_DATA_W'(-1000));
      write_register(REG_CLAMP_LO, CSR_DATA_W'(1000));
      write_register(REG_FULL_THR, CSR_DATA_W'(1000));
      send_position(-24'sd5000);
      send_position(24'sd5000);
      send_position(24'sd500);
      send_position(-24'sd500);
      send_position(24'sd0);
      drain_moves();
   endtask

   task automatic test_random_quiet();
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (3) run_random_block(33, 1'b0);
   endtask

   task automatic test_random_sender_gaps();
      send_idle_pct = 59;
      stall_pct     = 0;
      repeat (3) run_random_block(33, 1'b0);
   endtask

   task automatic test_random_receiver_stalls();
      send_idle_pct = 0;
      stall_pct     = 59;
      run_random_block(33, 1'b1);
      repeat (2) run_random_block(33, 1'b0);
   endtask

   task automatic test_random_both();
      send_idle_pct = 26;
      stall_pct     = 26;
      repeat (3) run_random_block(33, 1'b0);
   endtask

   initial begin
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_measured_position = '0;
      csr_write_en          = 1'b0;
      csr_index             = REG_TARGET;
      csr_write_data        = '0;
      settings.setpoint            = TARGET_RST;
      settings.gain_p              = GAIN_P_RST;
      settings.gain_i              = GAIN_I_RST;
      settings.gain_d              = GAIN_D_RST;
      settings.deadband            = DEADBAND_RST;
      settings.clamp_high          = CLAMP_HI_RST;
      settings.clamp_low           = CLAMP_LO_RST;
      settings.full_open_threshold = FULL_THR_RST;
      last_mag  = '0;
      older_mag = '0;
      held_dir  = DIR_NONE;
      held_open = OPEN_CLOSED;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_deadband_edges();
      test_position_extremes();
      test_register_extremes();
      test_crossed_clamps();
      test_random_quiet();
      test_random_sender_gaps();
      test_random_receiver_stalls();
      test_random_both();

      drain_moves();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_valve_incremental_pid_top: PASS");
      end else begin
         $display("tb_valve_incremental_pid_top: FAIL");
      end
      $finish;
   end

endmodule
